// ===== sv/gcd_pkg.sv =====
// Shared types, fixed-point widths and constant tables for the great-circle distance pipeline.
// Self-contained; every other module of the block imports this package.
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS    = 30;
    localparam int CORDIC_STAGES_DFLT = 32;

    // Lanes of the angle front end and of the rotation CORDIC bank.
    localparam int LANES     = 4;
    localparam int LANE_DLAT = 0;
    localparam int LANE_DLON = 1;
    localparam int LANE_LAT1 = 2;
    localparam int LANE_LAT2 = 3;

    localparam int UNIT_W  = 31;                       // angle magnitude, 1e-7 degree
    localparam int ZW      = ANGLE_FRAC_BITS + 4;      // signed angle accumulator
    localparam int XYW     = ANGLE_FRAC_BITS + 4;      // signed CORDIC vector
    localparam int MAGW    = ANGLE_FRAC_BITS + 2;      // unsigned sine/cosine magnitude
    localparam int RADW    = 2 * ANGLE_FRAC_BITS + 1;  // haversine term, Q(2F)
    localparam int ROOTW   = ANGLE_FRAC_BITS + 1;      // square root, QF
    localparam int TAB_SHIFT = 62 - ANGLE_FRAC_BITS;

    typedef logic signed [ZW-1:0]   t_angle;
    typedef logic signed [XYW-1:0]  t_xy;
    typedef logic        [MAGW-1:0] t_mag;
    typedef logic        [RADW-1:0] t_rad;
    typedef logic        [ROOTW-1:0] t_root;
    typedef logic        [UNIT_W-1:0] t_units;

    localparam logic [63:0]  PI_Q62   = 64'hC90FDAA22168C235;
    localparam logic [63:0]  GAIN_Q62 = 64'd2800459870029452954;

    // Radians per 1e-7 degree in Q92, rounded to nearest.
    localparam logic [127:0] RAD_WIDE =
        ((128'(PI_Q62) << 30) + 128'd900000000) / 128'd1800000000;
    localparam logic [63:0]  RAD_PER_UNIT = RAD_WIDE[63:0];

    localparam logic [63:0]  GAIN_QF =
        (GAIN_Q62 + (64'd1 << (TAB_SHIFT - 1))) >> TAB_SHIFT;
    localparam t_xy          GAIN_XY = $signed(GAIN_QF[XYW-1:0]);

    // floor(2^e / d) by long division, used only at elaboration.
    function automatic logic [63:0] pow2_div(input int e, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], (b == e)};
            if (rem >= d) begin
                rem    = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q(ANGLE_FRAC_BITS), from the Q62 alternating series.
    function automatic t_angle atan_q(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          e;
        acc = '0;
        if (i == 0) begin
            acc = (PI_Q62 + 64'd2) >> 2;
        end else begin
            for (int k = 0; k < 64; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = pow2_div(e, 64'(2 * k + 1));
                    if (k[0]) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        acc = (acc + (64'd1 << (TAB_SHIFT - 1))) >> TAB_SHIFT;
        return $signed(acc[ZW-1:0]);
    endfunction

endpackage

// ===== sv/gcd_angle.sv =====
// Front end: clamps latitudes, reduces the longitude difference and converts four
// angle magnitudes from 1e-7 degree units to fixed-point radians. Uses gcd_pkg.
module gcd_angle (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [30:0]   i_start_lat,
    input  logic signed [31:0]   i_start_lon,
    input  logic signed [30:0]   i_target_lat,
    input  logic signed [31:0]   i_target_lon,
    output logic                 o_valid,
    output gcd_pkg::t_angle      o_angle [gcd_pkg::LANES]
);
    import gcd_pkg::*;

    localparam logic signed [30:0] LAT_LIMIT  = 31'sd900000000;
    localparam logic signed [33:0] FULL_TURN  = 34'sd3600000000;
    localparam logic        [31:0] FULL_U     = 32'd3600000000;
    localparam logic        [31:0] HALF_U     = 32'd1800000000;
    localparam int                 HALF_SHIFT = 93 - ANGLE_FRAC_BITS;
    localparam int                 FULL_SHIFT = 92 - ANGLE_FRAC_BITS;
    localparam int                 SUM_W      = UNIT_W + 65;

    logic [4:0] r_v;

    // Stage 0: saturate latitudes, raw longitude difference.
    logic signed [30:0] r_lat1, r_lat2, n_lat1, n_lat2;
    logic signed [32:0] r_dlon;

    always_comb begin
        n_lat1 = i_start_lat;
        if (i_start_lat > LAT_LIMIT) begin
            n_lat1 = LAT_LIMIT;
        end else if (i_start_lat < -LAT_LIMIT) begin
            n_lat1 = -LAT_LIMIT;
        end
        n_lat2 = i_target_lat;
        if (i_target_lat > LAT_LIMIT) begin
            n_lat2 = LAT_LIMIT;
        end else if (i_target_lat < -LAT_LIMIT) begin
            n_lat2 = -LAT_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat1 <= n_lat1;
        r_lat2 <= n_lat2;
        r_dlon <= 33'(i_target_lon) - 33'(i_start_lon);
    end

    // Stage 1: longitude difference into [0, 360) degrees, latitude difference.
    logic signed [33:0] dl;
    logic signed [33:0] dl_sel;
    logic [31:0]        r_dred;
    logic signed [31:0] r_dlat;
    t_units             r_mlat1, r_mlat2;
    logic signed [30:0] neg_lat1, neg_lat2;

    always_comb begin
        dl = 34'(r_dlon);
        if (dl < -FULL_TURN) begin
            dl_sel = dl + FULL_TURN + FULL_TURN;
        end else if (dl < 34'sd0) begin
            dl_sel = dl + FULL_TURN;
        end else if (dl >= FULL_TURN) begin
            dl_sel = dl - FULL_TURN;
        end else begin
            dl_sel = dl;
        end
        neg_lat1 = -r_lat1;
        neg_lat2 = -r_lat2;
    end

    always_ff @(posedge i_clk) begin
        r_dred  <= dl_sel[31:0];
        r_dlat  <= 32'(r_lat2) - 32'(r_lat1);
        r_mlat1 <= r_lat1[30] ? neg_lat1[UNIT_W-1:0] : r_lat1[UNIT_W-1:0];
        r_mlat2 <= r_lat2[30] ? neg_lat2[UNIT_W-1:0] : r_lat2[UNIT_W-1:0];
    end

    // Stage 2: fold the longitude difference to at most half a turn.
    t_units             r_m [LANES];
    logic [31:0]        dl_fold;
    logic signed [31:0] neg_dlat;

    always_comb begin
        dl_fold  = (r_dred > HALF_U) ? (FULL_U - r_dred) : r_dred;
        neg_dlat = -r_dlat;
    end

    always_ff @(posedge i_clk) begin
        r_m[LANE_DLAT] <= r_dlat[31] ? neg_dlat[UNIT_W-1:0] : r_dlat[UNIT_W-1:0];
        r_m[LANE_DLON] <= dl_fold[UNIT_W-1:0];
        r_m[LANE_LAT1] <= r_mlat1;
        r_m[LANE_LAT2] <= r_mlat2;
    end

    // Stages 3 and 4: units times radians-per-unit in two 32-bit halves, then
    // recombine with round half up.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        localparam int SH = (l == LANE_DLAT || l == LANE_DLON) ? HALF_SHIFT : FULL_SHIFT;
        logic [UNIT_W+31:0] r_ph, r_pl;
        logic [SUM_W-1:0]   sum;
        t_angle             r_ang;

        always_comb begin
            sum = (SUM_W'(r_ph) << 32) + SUM_W'(r_pl) + (SUM_W'(1) << (SH - 1));
        end

        always_ff @(posedge i_clk) begin
            r_ph  <= (UNIT_W + 32)'(r_m[l]) * (UNIT_W + 32)'(RAD_PER_UNIT[63:32]);
            r_pl  <= (UNIT_W + 32)'(r_m[l]) * (UNIT_W + 32)'(RAD_PER_UNIT[31:0]);
            r_ang <= t_angle'(sum >> SH);
        end

        assign o_angle[l] = r_ang;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    assign o_valid = r_v[4];

endmodule

// ===== sv/gcd_cordic.sv =====
// Pipelined CORDIC, one micro-rotation per register stage, rotation or vectoring mode.
// Depends on gcd_pkg for widths and the arctangent table.
module gcd_cordic #(
    parameter int STAGES = gcd_pkg::CORDIC_STAGES_DFLT,
    parameter bit VECTOR = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gcd_pkg::t_xy    i_x,
    input  gcd_pkg::t_xy    i_y,
    input  gcd_pkg::t_angle i_z,
    output logic            o_valid,
    output gcd_pkg::t_xy    o_x,
    output gcd_pkg::t_xy    o_y,
    output gcd_pkg::t_angle o_z
);
    import gcd_pkg::*;

    t_xy         r_x [STAGES];
    t_xy         r_y [STAGES];
    t_angle      r_z [STAGES];
    logic [STAGES-1:0] r_v;

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam t_angle ATAN_G = atan_q(g);
        t_xy    x_in, y_in, n_x, n_y;
        t_angle z_in, n_z;
        logic   v_in, dir;

        if (g == 0) begin : g_head
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
            assign v_in = i_valid;
        end else begin : g_link
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
            assign v_in = r_v[g-1];
        end

        // Rotation drives z toward zero, vectoring drives y toward zero.
        always_comb begin
            dir = VECTOR ? y_in[XYW-1] : !z_in[ZW-1];
            if (dir) begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - ATAN_G;
            end else begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + ATAN_G;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[g] <= n_x;
            r_y[g] <= n_y;
            r_z[g] <= n_z;
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= v_in;
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_x     = r_x[STAGES-1];
    assign o_y     = r_y[STAGES-1];
    assign o_z     = r_z[STAGES-1];

endmodule

// ===== sv/gcd_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage, floor rounding.
// Depends on gcd_pkg for the radicand and root widths.
module gcd_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gcd_pkg::t_rad  i_rad,
    output logic           o_valid,
    output gcd_pkg::t_root o_root
);
    import gcd_pkg::*;

    localparam int TW = RADW + 2;

    t_rad  r_d [ROOTW];
    t_root r_r [ROOTW];
    logic [ROOTW-1:0] r_v;

    for (genvar g = 0; g < ROOTW; g++) begin : g_bit
        localparam int B = ROOTW - 1 - g;
        t_rad          d_in, n_d;
        t_root         r_in, n_r;
        logic          v_in;
        logic [TW-1:0] trial;

        if (g == 0) begin : g_head
            assign d_in = i_rad;
            assign r_in = '0;
            assign v_in = i_valid;
        end else begin : g_link
            assign d_in = r_d[g-1];
            assign r_in = r_r[g-1];
            assign v_in = r_v[g-1];
        end

        // d holds rad - root^2; setting bit B costs 2*root*2^B + 2^(2B).
        always_comb begin
            trial = (TW'(r_in) << (B + 1)) + (TW'(1) << (2 * B));
            n_d   = d_in;
            n_r   = r_in;
            if (TW'(d_in) >= trial) begin
                n_d    = d_in - trial[RADW-1:0];
                n_r[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_d[g] <= n_d;
            r_r[g] <= n_r;
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= v_in;
            end
        end
    end

    assign o_valid = r_v[ROOTW-1];
    assign o_root  = r_r[ROOTW-1];

endmodule

// ===== sv/great_circle_distance.sv =====
// Top level of the haversine great-circle distance pipeline.
// Depends on gcd_pkg, gcd_angle, gcd_cordic and gcd_sqrt.
//
//   Channel   Dir  Handshake                    Payload
//   item      in   start high while busy low    i_start_lat, i_start_lon,
//                                               i_target_lat, i_target_lon
//   result    out  o_done, one cycle            o_distance_mm
//   config    in   i_cfg_we                     i_cfg_wdata (earth radius, meters)
//
// The pipeline takes one item on every clock, so busy is held low. Each result
// reaches o_done after the front end, the two CORDIC chains, the 31-stage square
// root and the haversine and scaling registers. Results leave in the order the
// items came in, and nothing can hold them back. Reset clears every valid bit
// and loads the radius with 6378137 m.
module great_circle_distance #(
    parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] i_start_lat,
    input  logic signed [31:0] i_start_lon,
    input  logic signed [30:0] i_target_lat,
    input  logic signed [31:0] i_target_lon,
    output logic               o_done,
    output logic [34:0]        o_distance_mm,
    input  logic               i_cfg_we,
    input  logic [22:0]        i_cfg_wdata
);
    import gcd_pkg::*;

    localparam int           F           = ANGLE_FRAC_BITS;
    localparam int           SCALE_W     = 34;
    localparam int           DIST_W      = 35;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 34'd12756274000; // 2000 * 6378137
    localparam int           PW          = 2 * MAGW;
    localparam logic [RADW-1:0] ONE_Q2F  = RADW'(1) << (2 * F);

    // The radius is kept premultiplied by 2000: two for the diameter and a
    // thousand for millimeters.
    logic [SCALE_W-1:0] r_dist_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_dist_scale <= SCALE_W'(i_cfg_wdata) * SCALE_W'(2000);
        end
    end

    assign busy = 1'b0;

    // Front end: four angles in radians, the two differences already halved.
    logic   ang_valid;
    t_angle ang [LANES];

    gcd_angle u_angle (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start),
        .i_start_lat  (i_start_lat),
        .i_start_lon  (i_start_lon),
        .i_target_lat (i_target_lat),
        .i_target_lon (i_target_lon),
        .o_valid      (ang_valid),
        .o_angle      (ang)
    );

    // Rotation bank: sines of the half differences, cosines of the latitudes.
    logic [LANES-1:0] rot_v;
    t_xy              rot_x [LANES];
    t_xy              rot_y [LANES];

    for (genvar l = 0; l < LANES; l++) begin : g_rot
        gcd_cordic #(
            .STAGES (CORDIC_STAGES),
            .VECTOR (1'b0)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (ang_valid),
            .i_x     (GAIN_XY),
            .i_y     ('0),
            .i_z     (ang[l]),
            .o_valid (rot_v[l]),
            .o_x     (rot_x[l]),
            .o_y     (rot_y[l]),
            .o_z     ()
        );
    end

    // Haversine term. Q0 takes magnitudes, then the products alternate with
    // their roundings so that no stage holds both a multiplier and a wide add.
    logic [7:0] r_qv;
    t_mag       r_q0_slat, r_q0_slon, r_q0_c1, r_q0_c2;
    logic [PW-1:0] r_q1_m1, r_q1_sq;
    t_mag          r_q1_slon;
    t_mag          r_q2_c12, r_q2_slon;
    logic [PW-1:0] r_q2_sq;
    logic [PW-1:0] r_q3_m2, r_q3_sq;
    t_mag          r_q3_slon;
    t_mag          r_q4_u, r_q4_slon;
    logic [PW-1:0] r_q4_sq;
    logic [PW-1:0] r_q5_m3, r_q5_sq;
    logic [PW:0]   r_q6_asum;
    t_rad          r_q7_a, r_q7_b;

    t_xy         neg_ydl, neg_ydn;
    logic [PW:0] rnd_c12, rnd_u;
    logic [PW:0] b_raw;

    always_comb begin
        neg_ydl = -rot_y[LANE_DLAT];
        neg_ydn = -rot_y[LANE_DLON];
        rnd_c12 = {1'b0, r_q1_m1} + ((PW + 1)'(1) << (F - 1));
        rnd_u   = {1'b0, r_q3_m2} + ((PW + 1)'(1) << (F - 1));
        b_raw   = (PW + 1)'(ONE_Q2F) - r_q6_asum;
    end

    always_ff @(posedge i_clk) begin
        r_q0_slat <= rot_y[LANE_DLAT][XYW-1] ? neg_ydl[MAGW-1:0] : rot_y[LANE_DLAT][MAGW-1:0];
        r_q0_slon <= rot_y[LANE_DLON][XYW-1] ? neg_ydn[MAGW-1:0] : rot_y[LANE_DLON][MAGW-1:0];
        r_q0_c1   <= rot_x[LANE_LAT1][XYW-1] ? '0 : rot_x[LANE_LAT1][MAGW-1:0];
        r_q0_c2   <= rot_x[LANE_LAT2][XYW-1] ? '0 : rot_x[LANE_LAT2][MAGW-1:0];

        r_q1_m1   <= PW'(r_q0_c1) * PW'(r_q0_c2);
        r_q1_sq   <= PW'(r_q0_slat) * PW'(r_q0_slat);
        r_q1_slon <= r_q0_slon;

        r_q2_c12  <= rnd_c12[F+MAGW-1:F];
        r_q2_sq   <= r_q1_sq;
        r_q2_slon <= r_q1_slon;

        r_q3_m2   <= PW'(r_q2_c12) * PW'(r_q2_slon);
        r_q3_sq   <= r_q2_sq;
        r_q3_slon <= r_q2_slon;

        r_q4_u    <= rnd_u[F+MAGW-1:F];
        r_q4_sq   <= r_q3_sq;
        r_q4_slon <= r_q3_slon;

        r_q5_m3   <= PW'(r_q4_u) * PW'(r_q4_slon);
        r_q5_sq   <= r_q4_sq;

        r_q6_asum <= (PW + 1)'(r_q5_sq) + (PW + 1)'(r_q5_m3);

        // a is clamped to one; 1 - a is taken in parallel with the compare.
        if (r_q6_asum > (PW + 1)'(ONE_Q2F)) begin
            r_q7_a <= ONE_Q2F;
            r_q7_b <= '0;
        end else begin
            r_q7_a <= r_q6_asum[RADW-1:0];
            r_q7_b <= b_raw[RADW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= '0;
        end else begin
            r_qv <= {r_qv[6:0], rot_v[LANE_DLAT]};
        end
    end

    // Roots of a and 1 - a.
    logic  sa_valid, sb_valid;
    t_root sa, sb;

    gcd_sqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_qv[7]),
        .i_rad   (r_q7_a),
        .o_valid (sa_valid),
        .o_root  (sa)
    );

    gcd_sqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_qv[7]),
        .i_rad   (r_q7_b),
        .o_valid (sb_valid),
        .o_root  (sb)
    );

    // Vectoring CORDIC gives the half central angle atan2(sa, sb).
    logic   vec_valid;
    t_angle vec_z;

    gcd_cordic #(
        .STAGES (CORDIC_STAGES),
        .VECTOR (1'b1)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sa_valid & sb_valid),
        .i_x     ($signed(XYW'(sb))),
        .i_y     ($signed(XYW'(sa))),
        .i_z     ('0),
        .o_valid (vec_valid),
        .o_x     (),
        .o_y     (),
        .o_z     (vec_z)
    );

    // Scale by 2000*R: the 34-bit scale is split so that each product stays
    // within 32 bits a side, then the halves are joined and rounded.
    logic [2:0]            r_fv;
    logic [ROOTW-1:0]      r_zc;
    logic [ROOTW+31:0]     r_pl;
    logic [ROOTW+1:0]      r_ph;
    logic [DIST_W-1:0]     r_dist;
    logic [ROOTW+SCALE_W:0] dist_sum;

    always_comb begin
        dist_sum = ((ROOTW + SCALE_W + 1)'(r_ph) << 32) + (ROOTW + SCALE_W + 1)'(r_pl)
                 + ((ROOTW + SCALE_W + 1)'(1) << (F - 1));
    end

    always_ff @(posedge i_clk) begin
        r_zc   <= vec_z[ZW-1] ? '0 : vec_z[ROOTW-1:0];
        r_pl   <= (ROOTW + 32)'(r_zc) * (ROOTW + 32)'(r_dist_scale[31:0]);
        r_ph   <= (ROOTW + 2)'(r_zc) * (ROOTW + 2)'(r_dist_scale[SCALE_W-1:32]);
        r_dist <= dist_sum[F+DIST_W-1:F];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else begin
            r_fv <= {r_fv[1:0], vec_valid};
        end
    end

    assign o_done        = r_fv[2];
    assign o_distance_mm = r_dist;

endmodule

// ===== tb/sv/tb_great_circle_distance.sv =====
// Self-checking testbench for the great_circle_distance pipeline.
// Depends on the RTL only (great_circle_distance and gcd_pkg); predicts every distance itself.
module tb_great_circle_distance;

    // Fixed-point shape of the predictor; it matches the default build of the block.
    localparam int  FRAC        = gcd_pkg::ANGLE_FRAC_BITS;
    localparam int  STAGES      = gcd_pkg::CORDIC_STAGES_DFLT;
    // Delay from an item going in to its result coming out, in the default build.
    localparam int  LATENCY     = 2 * STAGES + 47;
    localparam int  NUM_RANDOM  = 1620;
    localparam longint HALF_TURN = 64'sd1800000000;
    localparam longint FULL_TURN = 64'sd3600000000;
    localparam longint LAT_LIMIT = 64'sd900000000;
    localparam logic [22:0] RADIUS_RESET = 23'd6378137;
    localparam logic [22:0] RADIUS_MIN   = 23'd6000000;
    localparam logic [22:0] RADIUS_MAX   = 23'd7000000;
    localparam logic [22:0] RADIUS_ZERO  = 23'd0;
    localparam logic [22:0] RADIUS_ONES  = 23'h7FFFFF;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [30:0] i_start_lat = '0;
    logic signed [31:0] i_start_lon = '0;
    logic signed [30:0] i_target_lat = '0;
    logic signed [31:0] i_target_lon = '0;
    logic               o_done;
    logic [34:0]        o_distance_mm;
    logic               i_cfg_we = 1'b0;
    logic [22:0]        i_cfg_wdata = '0;

    // Predictor state: the radius as the block holds it, and the constant tables.
    logic [22:0]  radius_m = RADIUS_RESET;
    longint       atan_tab [STAGES];
    longint       cordic_gain;
    logic [127:0] rad_per_unit;

    logic [34:0]  distance_queue [$];
    int           error_count = 0;
    bit           no_gaps = 1'b0;

    great_circle_distance uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_start_lat   (i_start_lat),
        .i_start_lon   (i_start_lon),
        .i_target_lat  (i_target_lat),
        .i_target_lon  (i_target_lon),
        .o_done        (o_done),
        .o_distance_mm (o_distance_mm),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Generous ceiling on the length of the whole run.
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Builds the arctangent table, the CORDIC gain and the radians-per-unit scale.
    // The table and the gain start in Q62 and are rounded half up into Q(FRAC); the scale is Q92.
    function automatic void build_constants();
        logic [63:0] pi_q62;
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        pi_q62 = 64'hC90FDAA22168C235;
        cordic_gain = longint'((64'd2800459870029452954 + (64'd1 << (61 - FRAC)))
                               >> (62 - FRAC));
        atan_tab[0] = longint'((((pi_q62 + 64'd2) >> 2) + (64'd1 << (61 - FRAC)))
                               >> (62 - FRAC));
        for (int i = 1; i < STAGES; i++) begin
            sum = '0;
            for (int k = 0; k < 64; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = (64'd1 << e) / 64'(2 * k + 1);
                    if (k % 2 == 1) sum = sum - term;
                    else sum = sum + term;
                end
            end
            atan_tab[i] = longint'((sum + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
        end
        rad_per_unit = ((128'(pi_q62) << 30) + 128'd900000000) / 128'd1800000000;
    endfunction

    // Angle in Q(FRAC) radians of a magnitude in 1e-7 degree; half selects the half angle.
    function automatic longint units_to_rad(logic [127:0] units, bit half);
        int s;
        s = (half ? 93 : 92) - FRAC;
        return longint'((units * rad_per_unit + (128'd1 << (s - 1))) >> s);
    endfunction

    // Rotation-mode CORDIC from (gain, 0); arithmetic shifts give the floor.
    function automatic void rotate_angle(input longint z, output longint cos_q,
                                         output longint sin_q);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = cordic_gain;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab[i];
            end
        end
        cos_q = x;
        sin_q = y;
    endfunction

    function automatic logic [127:0] magnitude(longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic logic [127:0] floor_sqrt(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int j = 45; j >= 0; j--) begin
            c = r | (128'd1 << j);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic longint clamp_lat(logic signed [30:0] lat);
        longint v;
        v = lat;
        if (v > LAT_LIMIT) v = LAT_LIMIT;
        if (v < -LAT_LIMIT) v = -LAT_LIMIT;
        return v;
    endfunction

    // Expected haversine distance in millimeters for one pair of points.
    function automatic logic [34:0] haversine_mm(logic signed [30:0] lat_a,
                                                 logic signed [31:0] lon_a,
                                                 logic signed [30:0] lat_b,
                                                 logic signed [31:0] lon_b,
                                                 logic [22:0] radius);
        longint       lat1;
        longint       lat2;
        longint       dlon;
        longint       c1;
        longint       c2;
        longint       s_dlat;
        longint       s_dlon;
        longint       unused;
        longint       xs;
        longint       ys;
        longint       dx;
        longint       dy;
        longint       z;
        logic [127:0] c12;
        logic [127:0] u;
        logic [127:0] hav_a;
        logic [127:0] hav_b;
        logic [127:0] one_q;
        logic [127:0] span_mm;
        lat1 = clamp_lat(lat_a);
        lat2 = clamp_lat(lat_b);
        dlon = longint'(lon_b) - longint'(lon_a);
        dlon = ((dlon % FULL_TURN) + FULL_TURN) % FULL_TURN;
        if (dlon > HALF_TURN) dlon = FULL_TURN - dlon;

        rotate_angle(units_to_rad(magnitude(lat2 - lat1), 1'b1), unused, s_dlat);
        rotate_angle(units_to_rad(128'(dlon), 1'b1), unused, s_dlon);
        rotate_angle(units_to_rad(magnitude(lat1), 1'b0), c1, unused);
        rotate_angle(units_to_rad(magnitude(lat2), 1'b0), c2, unused);
        if (c1 < 0) c1 = 0;
        if (c2 < 0) c2 = 0;

        c12 = (128'(c1) * 128'(c2) + (128'd1 << (FRAC - 1))) >> FRAC;
        u = (c12 * magnitude(s_dlon) + (128'd1 << (FRAC - 1))) >> FRAC;
        one_q = 128'd1 << (2 * FRAC);
        hav_a = magnitude(s_dlat) * magnitude(s_dlat) + u * magnitude(s_dlon);
        if (hav_a > one_q) hav_a = one_q;
        hav_b = one_q - hav_a;

        // Vectoring CORDIC on (sqrt(1-a), sqrt(a)) leaves the half central angle in z.
        xs = longint'(floor_sqrt(hav_b));
        ys = longint'(floor_sqrt(hav_a));
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys >= 0) begin
                xs = xs + dx;
                ys = ys - dy;
                z = z + atan_tab[i];
            end else begin
                xs = xs - dx;
                ys = ys + dy;
                z = z - atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        span_mm = (128'd2000 * 128'(radius) * 128'(z) + (128'd1 << (FRAC - 1))) >> FRAC;
        return span_mm[34:0];
    endfunction

    task automatic report_mismatch(string what, logic [34:0] want, logic [34:0] got);
        $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
        error_count++;
    endtask

    // Watches both sides at every edge. Values read here are the ones from before
    // the edge, so the order of processes within the time step does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) radius_m <= i_cfg_wdata;
            if (start && !busy) begin
                distance_queue.push_back(haversine_mm(i_start_lat, i_start_lon,
                                                      i_target_lat, i_target_lon,
                                                      radius_m));
            end
            if (o_done) begin
                if (distance_queue.size() == 0) begin
                    report_mismatch("distance with no item waiting", '0, o_distance_mm);
                end else if (o_distance_mm !== distance_queue[0]) begin
                    report_mismatch("distance_mm", distance_queue[0], o_distance_mm);
                    void'(distance_queue.pop_front());
                end else begin
                    void'(distance_queue.pop_front());
                end
            end
        end
    end

    // Offers one item and returns at the edge that takes it. Start stays high
    // unless the next call idles first, so back-to-back items go in every cycle.
    // Before about one item in five the sender idles first, which keeps it
    // quiet for roughly a third of the time.
    task automatic send_item(logic signed [30:0] lat_a, logic signed [31:0] lon_a,
                             logic signed [30:0] lat_b, logic signed [31:0] lon_b);
        if (!no_gaps && $urandom_range(99) < 19) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_start_lat  <= lat_a;
        i_start_lon  <= lon_a;
        i_target_lat <= lat_b;
        i_target_lon <= lon_b;
        do @(posedge i_clk); while (busy);
    endtask

    // Lets the pipeline empty: waits for every result, then a short settle.
    task automatic wait_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (distance_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Radius writes happen only with the pipeline empty.
    task automatic write_radius(logic [22:0] radius);
        wait_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= radius;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [30:0] random_lat();
        if ($urandom_range(9) == 0) return 31'($urandom);
        return 31'(longint'($urandom_range(1800000000)) - LAT_LIMIT);
    endfunction

    function automatic logic signed [31:0] random_lon();
        if ($urandom_range(9) == 0) return 32'($urandom);
        return 32'(longint'($urandom_range(32'd3600000000)) - HALF_TURN);
    endfunction

    // Edges of every field, coincident and antipodal points, out-of-range latitudes
    // that must saturate, and longitude spans that wrap past half a turn.
    task automatic test_directed_points();
        send_item(31'sd0, 32'sd0, 31'sd0, 32'sd0);
        send_item(31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0);
        send_item(-31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000);
        send_item(31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000);
        send_item(31'sd0, 32'sd0, 31'sd0, 32'sd1800000000);
        send_item(31'sd0, -32'sd900000000, 31'sd0, 32'sd900000000);
        send_item(31'sd0, 32'sd0, 31'sd0, 32'sd1800000001);
        send_item(31'sd0, 32'sh80000000, 31'sd0, 32'sh7FFFFFFF);
        send_item(31'sd0, 32'sh7FFFFFFF, 31'sd0, 32'sh80000000);
        send_item(31'sh40000000, 32'sd0, 31'sh3FFFFFFF, 32'sd100);
        send_item(31'sh3FFFFFFF, 32'sd0, 31'sd0, 32'sd0);
        send_item(31'sh40000000, 32'sd0, 31'sd0, 32'sd0);
        send_item(31'sd900000000, 32'sd123456789, 31'sd900000000, -32'sd987654321);
        send_item(31'sd0, 32'sd0, 31'sd1, 32'sd0);
        send_item(31'sd0, 32'sd0, 31'sd0, -32'sd1);
        send_item(31'sd515000000, -32'sd1000000, 31'sd407000000, -32'sd740000000);
        send_item(-31'sd338000000, 32'sd1512000000, 31'sd517000000, -32'sd1000000);
        send_item(31'sd450000000, 32'sd0, -31'sd450000000, 32'sd1800000000);
        send_item(-31'sd1, 32'sh7FFFFFFF, 31'sh7FFFFFFF, 32'sh7FFFFFFF);
        wait_results();
    endtask

    // Radius register at its reset value, both ends of its range, zero and all ones.
    task automatic test_radius_settings();
        logic [22:0] radii [5];
        radii = '{RADIUS_MIN, RADIUS_MAX, RADIUS_ZERO, RADIUS_ONES, RADIUS_RESET};
        foreach (radii[r]) begin
            write_radius(radii[r]);
            send_item(31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0);
            send_item(31'sd0, 32'sd0, 31'sd0, 32'sd1);
            send_item(random_lat(), random_lon(), random_lat(), random_lon());
        end
        wait_results();
    endtask

    // Random pairs under a spread of radii. Some pairs sit close together so the
    // small-angle end of the arctangent gets exercised along with long spans.
    task automatic test_random_pairs();
        logic signed [30:0] lat_a;
        logic signed [31:0] lon_a;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 270 == 0) begin
                case (n / 270)
                    1: write_radius(RADIUS_MIN);
                    2: write_radius(RADIUS_MAX);
                    3: write_radius(23'($urandom_range(6000000, 7000000)));
                    4: write_radius(23'($urandom));
                    5: write_radius(RADIUS_RESET);
                    default: ;
                endcase
            end
            // A long run with the sender never idling.
            no_gaps = (n >= 600 && n < 900);
            // Hold the sender back once until the pipeline is empty.
            if (n == 1000) wait_results();
            lat_a = random_lat();
            lon_a = random_lon();
            if ($urandom_range(3) == 0) begin
                send_item(lat_a, lon_a,
                          31'(lat_a + $signed($urandom_range(2000)) - 1000),
                          32'(lon_a + $signed($urandom_range(2000)) - 1000));
            end else begin
                send_item(lat_a, lon_a, random_lat(), random_lon());
            end
        end
        no_gaps = 1'b0;
        wait_results();
    endtask

    initial begin
        build_constants();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_points();
        test_radius_settings();
        test_random_pairs();

        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0 && distance_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
